@@ design/i8gemv_pkg.sv @@
// shared types and constants for the int8 gemv row dot-product block
// no dependencies; imported by every module of the block
package i8gemv_pkg;

   localparam int unsigned PROD_W = 17;
   localparam int unsigned DATA_W = 16;
   localparam logic [7:0]  BYTE_BIAS = 8'h80;
   localparam logic [DATA_W-1:0] SAT_POS = 16'h7FFF;
   localparam logic [DATA_W-1:0] SAT_NEG = 16'h8000;

   typedef enum logic [1:0] {
      CSR_ALPHA = 2'd0,
      CSR_BETA  = 2'd1,
      CSR_COMP  = 2'd2
   } csr_index_type;

   typedef logic signed [PROD_W-1:0] prod_type;

   // finished row leaving the merge stage
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] comp_sum;
      logic [DATA_W-1:0] prior;
   } stage2_type;

endpackage

@@ design/i8gemv_lane.sv @@
// one product lane: biased unsigned row byte times signed vector byte
// depends on i8gemv_pkg
module i8gemv_lane (
   input  logic                 clock,
   input  logic                 load,
   input  logic signed [7:0]    row,
   input  logic signed [7:0]    vec,
   output i8gemv_pkg::prod_type prod
);
   import i8gemv_pkg::*;

   logic [7:0] biased;
   prod_type   prod_in;
   prod_type   prod_ff;

   // offset by 128 is a flip of the sign bit
   assign biased  = row ^ BYTE_BIAS;
   assign prod_in = $signed({1'b0, biased}) * vec;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

@@ design/i8gemv_merge.sv @@
// merge stage: saturating pair sum, wrapping accumulator, compensation
// depends on i8gemv_pkg; fed by two i8gemv_lane instances
module i8gemv_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic                   last,
   input  logic [15:0]            prior,
   input  i8gemv_pkg::prod_type   prod_even,
   input  i8gemv_pkg::prod_type   prod_odd,
   input  logic [15:0]            offset_comp,
   input  logic                   next_ready,
   output i8gemv_pkg::stage2_type s2,
   output logic                   last_ready
);
   import i8gemv_pkg::*;

   logic signed [PROD_W:0] pair_sum;
   logic                   pair_fits;
   logic [DATA_W-1:0]      pair_sat;
   logic [DATA_W-1:0]      acc_sum;
   logic [DATA_W-1:0]      acc_in, acc_ff;
   logic                   push;
   logic                   s2_valid_in, s2_valid_ff;
   logic [DATA_W-1:0]      s2_comp_ff, s2_prior_ff;

   assign pair_sum  = {prod_even[PROD_W-1], prod_even} + {prod_odd[PROD_W-1], prod_odd};
   assign pair_fits = (pair_sum[PROD_W:DATA_W-1] == {(PROD_W-DATA_W+2){pair_sum[PROD_W]}});

   always_comb begin
      if (pair_fits) begin
         pair_sat = pair_sum[DATA_W-1:0];
      end else if (pair_sum[PROD_W]) begin
         pair_sat = SAT_NEG;
      end else begin
         pair_sat = SAT_POS;
      end
   end

   assign acc_sum    = acc_ff + pair_sat;
   assign push       = s2_valid_ff && next_ready;
   assign last_ready = !s2_valid_ff || next_ready;

   always_comb begin
      acc_in = acc_ff;
      if (take) begin
         acc_in = last ? '0 : acc_sum;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (take && last) begin
         s2_valid_in = 1'b1;
      end else if (push) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         acc_ff      <= acc_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && last) begin
         s2_comp_ff  <= acc_sum - offset_comp;
         s2_prior_ff <= prior;
      end
   end

   assign s2.valid    = s2_valid_ff;
   assign s2.comp_sum = s2_comp_ff;
   assign s2.prior    = s2_prior_ff;

endmodule

@@ design/i8gemv_scale.sv @@
// scaling stage: alpha and beta products, final add, output register
// depends on i8gemv_pkg; takes finished rows from i8gemv_merge
module i8gemv_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  i8gemv_pkg::stage2_type s2,
   input  logic [15:0]            alpha,
   input  logic [15:0]            beta,
   output logic                   ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [15:0]     rsp_row_result
);
   import i8gemv_pkg::*;

   logic [2*DATA_W-1:0] alpha_prod, beta_prod;
   logic                push;
   logic                out_free;
   logic                s3_go;
   logic                s3_valid_in, s3_valid_ff;
   logic [DATA_W-1:0]   s3_alpha_ff, s3_beta_ff;
   logic                out_valid_in, out_valid_ff;
   logic [DATA_W-1:0]   out_data_ff;

   // only the low 16 bits are kept, so unsigned products give the same bits
   assign alpha_prod = s2.comp_sum * alpha;
   assign beta_prod  = s2.prior * beta;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s3_go    = s3_valid_ff && out_free;
   assign ready    = !s3_valid_ff || out_free;
   assign push     = s2.valid && ready;

   always_comb begin
      s3_valid_in = s3_valid_ff;
      if (push) begin
         s3_valid_in = 1'b1;
      end else if (s3_go) begin
         s3_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s3_go) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s3_alpha_ff <= alpha_prod[DATA_W-1:0];
         s3_beta_ff  <= beta_prod[DATA_W-1:0];
      end
      if (s3_go) begin
         out_data_ff <= s3_alpha_ff + s3_beta_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_row_result = $signed(out_data_ff);

endmodule

@@ design/int8_gemv_row_dot_s16.sv @@
// int8 gemv row dot product with int16 accumulate and alpha/beta scaling
// path: a last pair passes the input registers, the merge register, the scale register and the output register
// throughput: one pair per cycle while req_stall is low; the pair sum and accumulator add in the merge stage set it
// stall: a waiting result holds the output register; upstream stages fill up, then the input stalls
// reset: synchronous, clears all valids and the accumulator; alpha = 1, beta = 0, comp = 0
module int8_gemv_row_dot_s16 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [7:0]  req_row_even,
   input  logic signed [7:0]  req_row_odd,
   input  logic signed [7:0]  req_vec_even,
   input  logic signed [7:0]  req_vec_odd,
   input  logic signed [15:0] req_prior_out,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_row_result,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import i8gemv_pkg::*;

   logic              req_xfer;
   logic              s1_take;
   logic              s1_valid_in, s1_valid_ff;
   logic              s1_last_ff;
   logic [DATA_W-1:0] s1_prior_ff;
   prod_type          prod_even, prod_odd;
   logic              merge_last_ready;
   logic              scale_ready;
   stage2_type        s2;
   logic [DATA_W-1:0] alpha_ff, beta_ff, comp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 16'h0001;
         beta_ff  <= '0;
         comp_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_wdata;
            CSR_BETA:  beta_ff  <= csr_wdata;
            CSR_COMP:  comp_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a non-last pair only touches the accumulator, so it never waits
   assign s1_take   = s1_valid_ff && (!s1_last_ff || merge_last_ready);
   assign req_stall = s1_valid_ff && !s1_take;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_last_ff  <= req_last;
         s1_prior_ff <= req_prior_out;
      end
   end

   i8gemv_lane u_lane_even (
      .clock (clock),
      .load  (req_xfer),
      .row   (req_row_even),
      .vec   (req_vec_even),
      .prod  (prod_even)
   );

   i8gemv_lane u_lane_odd (
      .clock (clock),
      .load  (req_xfer),
      .row   (req_row_odd),
      .vec   (req_vec_odd),
      .prod  (prod_odd)
   );

   i8gemv_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .take        (s1_take),
      .last        (s1_last_ff),
      .prior       (s1_prior_ff),
      .prod_even   (prod_even),
      .prod_odd    (prod_odd),
      .offset_comp (comp_ff),
      .next_ready  (scale_ready),
      .s2          (s2),
      .last_ready  (merge_last_ready)
   );

   i8gemv_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .s2             (s2),
      .alpha          (alpha_ff),
      .beta           (beta_ff),
      .ready          (scale_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_result (rsp_row_result)
   );

endmodule

@@ design/i8gemv_checker.sv @@
// port-level checks for int8_gemv_row_dot_s16, attached by bind
// depends only on the top level's ports
module i8gemv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_row_result
);
   logic [2:0] pending_in, pending_ff;
   logic       row_in, row_out;

   assign row_in  = req_valid && !req_stall && req_last;
   assign row_out = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (row_in && !row_out) begin
         pending_in = pending_ff + 3'd1;
      end else if (!row_in && row_out) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // with the output empty every stage downstream of the input can move on
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while no result is waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_result))
      else $error("stalled result changed or dropped");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without a last pair transferred");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4)
      else $error("more rows in flight than pipeline stages");

endmodule

bind int8_gemv_row_dot_s16 i8gemv_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_last       (req_last),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_row_result (rsp_row_result)
);
